// ----- sv/limit_order_book_matcher_unit_macros.svh -----
// Assertion macros used by the order book matcher sequencer (lobm_ctrl).
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`ifndef SYNTH
`define LOBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lobm assertion failed");
`define LOBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lobm assertion failed");
`else
`define LOBM_ASSERT_IMP(lbl, ante, cons)
`define LOBM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/lobm_pkg.sv -----
// Types, constants and helper functions of the order book matcher.
package lobm_pkg;

  localparam int PRICE_W = 30;
  localparam int AMT_W   = 30;
  localparam int STORE_W = 48;
  localparam int HEAP_CAPACITY_DEF = 1024;
  localparam logic [29:0] BACKLOG_MOD = 30'd1000000007;
  localparam int ENTRY_W = PRICE_W + STORE_W;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [STORE_W-1:0] amount;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic [AMT_W-1:0]   traded;
    logic [29:0]        total;
    logic               full;
  } done_t;

  // True when entry a belongs nearer the heap top than entry b.
  function automatic logic ranks_above(entry_t a, entry_t b, logic highest);
    logic res;
    if (highest) begin
      res = (a.price > b.price) || ((a.price == b.price) && (a.amount > b.amount));
    end else begin
      res = (a.price < b.price) || ((a.price == b.price) && (a.amount < b.amount));
    end
    return res;
  endfunction

endpackage

// ----- sv/lobm_if.sv -----
// Valid/ready channel interfaces for orders and results.
interface lobm_in_if;
  import lobm_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic [AMT_W-1:0]   amount;
  logic               side;
  modport source (output valid, price, amount, side, input ready);
  modport sink (input valid, price, amount, side, output ready);
endinterface

interface lobm_out_if;
  import lobm_pkg::*;
  logic             valid;
  logic             ready;
  logic [AMT_W-1:0] traded_amount;
  logic [29:0]      backlog_mod;
  logic             backlog_full;
  modport source (output valid, traded_amount, backlog_mod, backlog_full, input ready);
  modport sink (input valid, traded_amount, backlog_mod, backlog_full, output ready);
endinterface

// ----- sv/lobm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/lobm_ctrl.sv -----
// Sequencer that matches orders and sifts both heaps held in the entry RAM.
module lobm_ctrl #(
  parameter int CAP = lobm_pkg::HEAP_CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ord_valid,
  output logic                           ord_ready,
  input  logic [lobm_pkg::PRICE_W-1:0]   ord_price,
  input  logic [lobm_pkg::AMT_W-1:0]     ord_amount,
  input  logic                           ord_side,
  output lobm_pkg::done_t                done,
  input  logic                           done_ready,
  output logic                           ram_we,
  output logic [$clog2(CAP)+1-1:0]       ram_waddr,
  output logic [lobm_pkg::ENTRY_W-1:0]   ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(CAP)+1-1:0]       ram_raddr,
  input  logic [lobm_pkg::ENTRY_W-1:0]   ram_rdata
);
  import lobm_pkg::*;
  `include "limit_order_book_matcher_unit_macros.svh"

  localparam int IW = $clog2(CAP);
  localparam int CW = $clog2(CAP + 1);
  localparam int LW = IW + 2;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_MREAD  = 14'b00000000000010,
    S_MCHK   = 14'b00000000000100,
    S_LAST   = 14'b00000000001000,
    S_RED    = 14'b00000000010000,
    S_ACC    = 14'b00000000100000,
    S_OWN    = 14'b00000001000000,
    S_OWNCHK = 14'b00000010000000,
    S_SD     = 14'b00000100000000,
    S_SDL    = 14'b00001000000000,
    S_SDR    = 14'b00010000000000,
    S_SU     = 14'b00100000000000,
    S_SUP    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t             state_r, state_nxt, ret_r, ret_nxt;
  logic [PRICE_W-1:0] price_r, price_nxt;
  logic [AMT_W-1:0]   amt_r, amt_nxt;
  logic [AMT_W-1:0]   rem_r, rem_nxt;
  logic [AMT_W-1:0]   traded_r, traded_nxt;
  logic               side_r, side_nxt;
  logic               full_r, full_nxt;
  logic [29:0]        total_r, total_nxt;
  logic [29:0]        v_r, v_nxt;
  logic               sub_r, sub_nxt;
  logic [CW-1:0]      buy_cnt_r, buy_cnt_nxt;
  logic [CW-1:0]      sell_cnt_r, sell_cnt_nxt;
  entry_t             x_r, x_nxt;
  entry_t             lc_r, lc_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic               hsel_r, hsel_nxt;

  entry_t             rd_e;
  logic [CW-1:0]      opp_cnt, own_cnt, opp_dec;
  logic               qual;
  logic [AMT_W-1:0]   take;
  logic [STORE_W-1:0] left;
  logic [STORE_W:0]   msum;
  logic [STORE_W-1:0] msat;
  logic [LW-1:0]      lidx, ridx, nx;
  logic [IW-1:0]      pidx;
  logic               hi;
  logic               l_above, r_above_x, r_above_l;
  logic [30:0]        acc_sum;

  assign rd_e    = entry_t'(ram_rdata);
  assign opp_cnt = side_r ? buy_cnt_r : sell_cnt_r;
  assign own_cnt = side_r ? sell_cnt_r : buy_cnt_r;
  assign opp_dec = opp_cnt - CW'(1);
  assign qual    = side_r ? (rd_e.price >= price_r) : (rd_e.price <= price_r);
  assign take    = (rd_e.amount < STORE_W'(rem_r)) ? rd_e.amount[AMT_W-1:0] : rem_r;
  assign left    = rd_e.amount - STORE_W'(take);
  assign msum    = {1'b0, rd_e.amount} + (STORE_W + 1)'(rem_r);
  assign msat    = msum[STORE_W] ? {STORE_W{1'b1}} : msum[STORE_W-1:0];
  assign lidx    = {1'b0, idx_r, 1'b1};
  assign ridx    = lidx + LW'(1);
  assign nx      = LW'(n_r);
  assign pidx    = IW'((idx_r - IW'(1)) >> 1);
  assign hi      = ~hsel_r;
  assign l_above   = ranks_above(lc_r, x_r, hi);
  assign r_above_x = ranks_above(rd_e, x_r, hi);
  assign r_above_l = ranks_above(rd_e, lc_r, hi);
  assign acc_sum   = {1'b0, total_r} + {1'b0, v_r};

  assign ord_ready   = (state_r == S_IDLE);
  assign done.valid  = (state_r == S_DONE);
  assign done.traded = traded_r;
  assign done.total  = total_r;
  assign done.full   = full_r;

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    price_nxt    = price_r;
    amt_nxt      = amt_r;
    rem_nxt      = rem_r;
    traded_nxt   = traded_r;
    side_nxt     = side_r;
    full_nxt     = full_r;
    total_nxt    = total_r;
    v_nxt        = v_r;
    sub_nxt      = sub_r;
    buy_cnt_nxt  = buy_cnt_r;
    sell_cnt_nxt = sell_cnt_r;
    x_nxt        = x_r;
    lc_nxt       = lc_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    hsel_nxt     = hsel_r;
    ram_we       = 1'b0;
    ram_waddr    = {hsel_r, idx_r};
    ram_wdata    = x_r;
    ram_re       = 1'b0;
    ram_raddr    = {~side_r, {IW{1'b0}}};

    case (state_r)
      S_IDLE: begin
        if (ord_valid) begin
          price_nxt  = ord_price;
          amt_nxt    = ord_amount;
          rem_nxt    = ord_amount;
          side_nxt   = ord_side;
          traded_nxt = '0;
          full_nxt   = 1'b0;
          state_nxt  = S_MREAD;
        end
      end
      S_MREAD: begin
        if (opp_cnt == '0) begin
          v_nxt     = traded_r;
          sub_nxt   = 1'b1;
          state_nxt = S_RED;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (qual) begin
          rem_nxt    = rem_r - take;
          traded_nxt = traded_r + take;
          if (left != '0) begin
            // Partly consumed top stays; re-sift it and stop matching.
            x_nxt     = '{price: rd_e.price, amount: left};
            idx_nxt   = '0;
            n_nxt     = opp_cnt;
            hsel_nxt  = ~side_r;
            ret_nxt   = S_RED;
            v_nxt     = traded_r + take;
            sub_nxt   = 1'b1;
            state_nxt = S_SD;
          end else begin
            if (side_r) begin
              buy_cnt_nxt = opp_dec;
            end else begin
              sell_cnt_nxt = opp_dec;
            end
            if (opp_dec == '0) begin
              state_nxt = S_MREAD;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = {~side_r, opp_dec[IW-1:0]};
              state_nxt = S_LAST;
            end
          end
        end else begin
          v_nxt     = traded_r;
          sub_nxt   = 1'b1;
          state_nxt = S_RED;
        end
      end
      S_LAST: begin
        x_nxt     = rd_e;
        idx_nxt   = '0;
        n_nxt     = opp_cnt;
        hsel_nxt  = ~side_r;
        ret_nxt   = S_MREAD;
        state_nxt = S_SD;
      end
      S_RED: begin
        if (v_r >= BACKLOG_MOD) begin
          v_nxt = v_r - BACKLOG_MOD;
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (sub_r) begin
          if (total_r >= v_r) begin
            total_nxt = total_r - v_r;
          end else begin
            total_nxt = total_r + (BACKLOG_MOD - v_r);
          end
          state_nxt = S_OWN;
        end else begin
          if (acc_sum >= {1'b0, BACKLOG_MOD}) begin
            total_nxt = 30'(acc_sum - {1'b0, BACKLOG_MOD});
          end else begin
            total_nxt = acc_sum[29:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_OWN: begin
        if (rem_r == '0) begin
          state_nxt = S_DONE;
        end else if (own_cnt != '0) begin
          ram_re    = 1'b1;
          ram_raddr = {side_r, {IW{1'b0}}};
          state_nxt = S_OWNCHK;
        end else begin
          x_nxt     = '{price: price_r, amount: STORE_W'(rem_r)};
          idx_nxt   = '0;
          hsel_nxt  = side_r;
          ret_nxt   = S_RED;
          v_nxt     = rem_r;
          sub_nxt   = 1'b0;
          if (side_r) begin
            sell_cnt_nxt = sell_cnt_r + CW'(1);
          end else begin
            buy_cnt_nxt = buy_cnt_r + CW'(1);
          end
          state_nxt = S_SU;
        end
      end
      S_OWNCHK: begin
        if (rd_e.price == price_r) begin
          // Merge into the top of the own backlog, saturating the amount.
          x_nxt     = '{price: rd_e.price, amount: msat};
          idx_nxt   = '0;
          n_nxt     = own_cnt;
          hsel_nxt  = side_r;
          ret_nxt   = S_RED;
          v_nxt     = 30'(msat - rd_e.amount);
          sub_nxt   = 1'b0;
          state_nxt = S_SD;
        end else if (own_cnt < CW'(CAP)) begin
          x_nxt     = '{price: price_r, amount: STORE_W'(rem_r)};
          idx_nxt   = own_cnt[IW-1:0];
          hsel_nxt  = side_r;
          ret_nxt   = S_RED;
          v_nxt     = rem_r;
          sub_nxt   = 1'b0;
          if (side_r) begin
            sell_cnt_nxt = sell_cnt_r + CW'(1);
          end else begin
            buy_cnt_nxt = buy_cnt_r + CW'(1);
          end
          state_nxt = S_SU;
        end else begin
          full_nxt  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SD: begin
        if (lidx >= nx) begin
          ram_we    = 1'b1;
          state_nxt = ret_r;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {hsel_r, lidx[IW-1:0]};
          state_nxt = S_SDL;
        end
      end
      S_SDL: begin
        lc_nxt = rd_e;
        if (ridx < nx) begin
          ram_re    = 1'b1;
          ram_raddr = {hsel_r, ridx[IW-1:0]};
          state_nxt = S_SDR;
        end else if (ranks_above(rd_e, x_r, hi)) begin
          ram_we    = 1'b1;
          ram_wdata = rd_e;
          idx_nxt   = lidx[IW-1:0];
          state_nxt = S_SD;
        end else begin
          ram_we    = 1'b1;
          state_nxt = ret_r;
        end
      end
      S_SDR: begin
        ram_we = 1'b1;
        if (l_above ? r_above_l : r_above_x) begin
          ram_wdata = rd_e;
          idx_nxt   = ridx[IW-1:0];
          state_nxt = S_SD;
        end else if (l_above) begin
          ram_wdata = lc_r;
          idx_nxt   = lidx[IW-1:0];
          state_nxt = S_SD;
        end else begin
          state_nxt = ret_r;
        end
      end
      S_SU: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ret_r;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {hsel_r, pidx};
          state_nxt = S_SUP;
        end
      end
      S_SUP: begin
        ram_we = 1'b1;
        if (ranks_above(x_r, rd_e, hi)) begin
          ram_wdata = rd_e;
          idx_nxt   = pidx;
          state_nxt = S_SU;
        end else begin
          state_nxt = ret_r;
        end
      end
      S_DONE: begin
        if (done_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      buy_cnt_r  <= '0;
      sell_cnt_r <= '0;
      total_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      buy_cnt_r  <= buy_cnt_nxt;
      sell_cnt_r <= sell_cnt_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r  <= price_nxt;
    amt_r    <= amt_nxt;
    rem_r    <= rem_nxt;
    traded_r <= traded_nxt;
    side_r   <= side_nxt;
    full_r   <= full_nxt;
    v_r      <= v_nxt;
    sub_r    <= sub_nxt;
    x_r      <= x_nxt;
    lc_r     <= lc_nxt;
    idx_r    <= idx_nxt;
    n_r      <= n_nxt;
    hsel_r   <= hsel_nxt;
  end

  `LOBM_ASSERT_IMP(a_cnt_bound, 1'b1, (buy_cnt_r <= CW'(CAP)) && (sell_cnt_r <= CW'(CAP)))
  `LOBM_ASSERT_IMP(a_units_kept, state_r != S_IDLE, ({1'b0, rem_r} + {1'b0, traded_r}) == {1'b0, amt_r})
  `LOBM_ASSERT_IMP(a_total_reduced, state_r == S_DONE, total_r < BACKLOG_MOD)
  `LOBM_ASSERT_NXT(a_full_no_store, (state_r == S_OWNCHK) && (state_nxt == S_DONE), full_r)

endmodule

// ----- sv/limit_order_book_matcher_unit.sv -----
// Top level of the limit order book matcher: channels, entry RAM and result register.
// Usage:
// Orders arrive on in_ch (price, amount, side) as valid/ready transfers; one
// result per order leaves on out_ch (traded_amount, backlog_mod, backlog_full).
// Both backlogs live in one RAM of 2 x HEAP_CAPACITY entries, rounded up to
// a power of two: buys in the lower half as a max-price heap, sells in the
// upper half as a min-price heap. The block works on one order at a time.
// Each fully consumed heap top and each heap level passed by a sift down or
// a sift up adds to the time from the input transfer to a valid result,
// since all of it goes through the single read port of the entry RAM, one
// access per cycle. The next order is taken in the cycle after the
// sequencer hands its result over.
// in_ch.ready is high only while the sequencer is idle; a finished result
// moves into an output register, so the next order is taken even while
// out_ch waits. If out_ch stalls with a result already held, the sequencer
// holds its own result until the register frees.
// Synchronous active-low reset empties both backlogs and clears the total;
// the RAM contents are not cleared, since only live entries are ever read.
module limit_order_book_matcher_unit #(
  parameter int HEAP_CAPACITY = lobm_pkg::HEAP_CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lobm_in_if.sink    in_ch,
  lobm_out_if.source out_ch
);
  import lobm_pkg::*;

  localparam int IW = $clog2(HEAP_CAPACITY);

  done_t              done;
  logic               done_ready;
  logic               ram_we, ram_re;
  logic [IW:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic               out_valid_r, out_valid_nxt;
  logic [AMT_W-1:0]   out_traded_r;
  logic [29:0]        out_total_r;
  logic               out_full_r;

  // The sequencer does all matching and heap maintenance.
  lobm_ctrl #(.CAP(HEAP_CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .ord_valid  (in_ch.valid),
    .ord_ready  (in_ch.ready),
    .ord_price  (in_ch.price),
    .ord_amount (in_ch.amount),
    .ord_side   (in_ch.side),
    .done       (done),
    .done_ready (done_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Lower half holds the buy heap, upper half the sell heap.
  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(2 * (2 ** IW))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The result register is free when empty or when its transfer happens now.
  assign done_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done.valid && done_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid && done_ready) begin
      out_traded_r <= done.traded;
      out_total_r  <= done.total;
      out_full_r   <= done.full;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.traded_amount = out_traded_r;
  assign out_ch.backlog_mod   = out_total_r;
  assign out_ch.backlog_full  = out_full_r;

endmodule
